FILE: sv/spq_pkg.sv
// Shared types, sizes and codes for the three-class strict priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_CLASSES = 3;
  localparam int SLOTS       = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(SLOTS);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int JOBS_W      = $clog2(SLOTS + 1);
  localparam int PAGES_W     = $clog2(SLOTS * 65535 + 1);
  localparam int JOBS_MAX    = 63;
  localparam int PAGES_MAX   = 4194303;

  typedef logic [1:0] class_t;
  localparam class_t CLASS_URGENT   = 2'd0;
  localparam class_t CLASS_PRIORITY = 2'd1;
  localparam class_t CLASS_NORMAL   = 2'd2;
  localparam class_t CLASS_INVALID  = 2'd3;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_SERVE   = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_QUEUED  = 2'd0;
  localparam status_t ST_SERVED  = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_DROPPED = 2'd3;

  typedef struct packed {
    logic        command;
    class_t      job_class;
    logic [15:0] job_id;
    logic [23:0] job_size;
    logic [15:0] job_pages;
    logic [11:0] job_year;
  } job_t;

  typedef struct packed {
    status_t     status;
    class_t      served_class;
    logic [15:0] out_id;
    logic [23:0] out_size;
    logic [15:0] out_pages;
    logic [11:0] out_year;
    logic [5:0]  total_jobs;
    logic [21:0] total_pages;
  } result_t;

  typedef struct packed {
    logic [15:0] id;
    logic [23:0] size;
    logic [15:0] pages;
    logic [11:0] year;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic take;
    logic fetch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic serve_hit;
  } ctrl_stat_t;

endpackage

FILE: sv/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/spq_ctrl.sv
// Controller: request handshake sequencing for the strict priority queue.
module spq_ctrl import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  logic       result_stall,
  input  ctrl_stat_t stat,
  output logic       job_stall,
  output logic       result_valid,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_SEND} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            if (stat.serve_hit) begin
              state <= S_FETCH;
            end else begin
              state        <= S_SEND;
              result_valid <= 1'b1;
            end
          end
        end
        S_FETCH: begin
          state        <= S_SEND;
          result_valid <= 1'b1;
        end
        S_SEND: begin
          if (!result_stall) begin
            state        <= S_IDLE;
            result_valid <= 1'b0;
          end
        end
        default: begin
          state        <= S_IDLE;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    job_stall = (state != S_IDLE);
    cmd.take  = (state == S_IDLE) && job_valid;
    cmd.fetch = (state == S_FETCH);
  end

endmodule

FILE: sv/spq_dp.sv
// Datapath: queue storage, per-class pointers and counts, running totals.
module spq_dp import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       job,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat,
  output result_t    result
);

  logic [IDX_W-1:0]   head  [NUM_CLASSES];
  logic [IDX_W-1:0]   tail  [NUM_CLASSES];
  logic [CNT_W-1:0]   count [NUM_CLASSES];
  logic [JOBS_W-1:0]  jobs_sum;
  logic [PAGES_W-1:0] pages_sum;
  status_t            status;
  class_t             served_class;

  logic              class_ok;
  class_t            enq_cls;
  class_t            srv_cls;
  logic              enq_ok;
  logic              any_queued;
  logic              is_serve;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  entry_t            wdata;
  entry_t            rdata;
  logic              served;

  function automatic logic [ADDR_W-1:0] slot(input class_t cls, input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(cls) * ADDR_W'(QUEUE_DEPTH);
    return base + ADDR_W'(idx);
  endfunction

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  always_comb begin
    is_serve       = (job.command == CMD_SERVE);
    class_ok       = (job.job_class != CLASS_INVALID);
    enq_cls        = class_ok ? job.job_class : CLASS_URGENT;
    enq_ok         = class_ok && (count[enq_cls] != CNT_W'(QUEUE_DEPTH));
    any_queued     = (count[0] != '0) || (count[1] != '0) || (count[2] != '0);
    srv_cls        = (count[0] != '0) ? CLASS_URGENT :
                     (count[1] != '0) ? CLASS_PRIORITY : CLASS_NORMAL;
    stat.serve_hit = is_serve && any_queued;
    wr_en          = cmd.take && !is_serve && enq_ok;
    rd_en          = cmd.take && stat.serve_hit;
    waddr          = slot(enq_cls, tail[enq_cls]);
    raddr          = slot(srv_cls, head[srv_cls]);
    wdata.id       = job.job_id;
    wdata.size     = job.job_size;
    wdata.pages    = job.job_pages;
    wdata.year     = job.job_year;
  end

  spq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= '0;
      end
      jobs_sum     <= '0;
      pages_sum    <= '0;
      status       <= ST_QUEUED;
      served_class <= CLASS_URGENT;
    end else begin
      if (wr_en) begin
        tail[enq_cls]  <= advance(tail[enq_cls]);
        count[enq_cls] <= count[enq_cls] + CNT_W'(1);
        jobs_sum       <= jobs_sum + JOBS_W'(1);
        pages_sum      <= pages_sum + PAGES_W'(job.job_pages);
      end
      if (rd_en) begin
        head[srv_cls]  <= advance(head[srv_cls]);
        count[srv_cls] <= count[srv_cls] - CNT_W'(1);
        jobs_sum       <= jobs_sum - JOBS_W'(1);
      end
      if (cmd.take) begin
        if (is_serve) begin
          status <= any_queued ? ST_SERVED : ST_EMPTY;
        end else begin
          status <= enq_ok ? ST_QUEUED : ST_DROPPED;
        end
        served_class <= rd_en ? srv_cls : CLASS_URGENT;
      end
      if (cmd.fetch) begin
        pages_sum <= pages_sum - PAGES_W'(rdata.pages);
      end
    end
  end

  always_comb begin
    served              = (status == ST_SERVED);
    result.status       = status;
    result.served_class = served_class;
    result.out_id       = served ? rdata.id    : '0;
    result.out_size     = served ? rdata.size  : '0;
    result.out_pages    = served ? rdata.pages : '0;
    result.out_year     = served ? rdata.year  : '0;
    result.total_jobs   = (32'(jobs_sum) > JOBS_MAX) ? 6'(JOBS_MAX) : 6'(jobs_sum);
    result.total_pages  = (32'(pages_sum) > PAGES_MAX) ? 22'(PAGES_MAX) : 22'(pages_sum);
  end

endmodule

FILE: sv/strict_priority_three_queue.sv
// Three-class strict priority job queue, top level.
// Timing: an enqueue or an empty/dropped request shows its result in the cycle after
// acceptance; a serve passes S_FETCH, where the pages total drops, before S_SEND.
// A new request is taken only in S_IDLE; job_stall holds it until the last result leaves.
// Reset (rst, synchronous): all queues empty, totals zero; RAM contents are not cleared.
module strict_priority_three_queue import spq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_stall,
  input  job_t    job,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .result_stall(result_stall),
    .stat        (stat),
    .job_stall   (job_stall),
    .result_valid(result_valid),
    .cmd         (cmd)
  );

  spq_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .job   (job),
    .cmd   (cmd),
    .stat  (stat),
    .result(result)
  );

endmodule
